FILE: hw/rtl/tkr_pkg.sv
// shared types and constants of the triangle-kernel resampler
package tkr_pkg;

  localparam int RATE_BITS = 16;
  localparam int TIME_W = 32;
  localparam int PERIOD_W = 15;
  localparam int WEIGHT_W = 17;
  localparam int FRAC_BITS = 16;
  localparam int GRID_W = 47;
  localparam int LOOKAHEAD = 3;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 15'd5000;
  localparam logic REG_GRID_PERIOD = 1'b0;

  typedef struct packed {
    logic [TIME_W-1:0]           sample_time;
    logic signed [RATE_BITS-1:0] rate_x;
    logic signed [RATE_BITS-1:0] rate_y;
    logic signed [RATE_BITS-1:0] rate_z;
  } in_item_t;

  typedef struct packed {
    logic [TIME_W-1:0]           grid_time;
    logic signed [RATE_BITS-1:0] out_x;
    logic signed [RATE_BITS-1:0] out_y;
    logic signed [RATE_BITS-1:0] out_z;
    logic                        window_empty;
    logic                        window_overflow;
    logic                        last_of_burst;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_GRID,
    ST_CHECK,
    ST_READ,
    ST_READ_WAIT,
    ST_WDIV,
    ST_MAC,
    ST_ACC,
    ST_FINISH,
    ST_QDIV,
    ST_QWAIT,
    ST_ADVANCE,
    ST_PRUNE,
    ST_PRUNE_WAIT,
    ST_LAST,
    ST_PUSH,
    ST_INSERT,
    ST_INSERT_WAIT,
    ST_WRITE
  } state_t;

endpackage

FILE: hw/rtl/tkr_divider.sv
// unsigned restoring divider, one quotient bit per cycle
module tkr_divider #(
  parameter int N = 32,
  parameter int M = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [M-1:0] divisor,
  output logic         done,
  output logic [N-1:0] quotient
);

  localparam int CNW = $clog2(N + 1);

  logic [N-1:0]   quo_r;
  logic [M-1:0]   rem_r;
  logic [M-1:0]   dvs_r;
  logic [CNW-1:0] cnt_r;
  logic           done_r;
  logic [M:0]     shifted;
  logic [M:0]     diff;
  logic           ge;

  // trial subtract of the shifted remainder
  assign shifted = {rem_r, quo_r[N-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign ge      = shifted >= {1'b0, dvs_r};

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNW'(N);
      end else if (cnt_r != '0) begin
        cnt_r  <= cnt_r - CNW'(1);
        done_r <= (cnt_r == CNW'(1));
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? diff[M-1:0] : shifted[M-1:0];
      quo_r <= {quo_r[N-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: hw/rtl/triangle_kernel_resampler.sv
// Steps: a beat that emits nothing passes grid, check, insert, an insert wait that drops the
// oldest entry if the window is full, and write; a grid point reads each entry, divides
// a weight per hit (an entry inside the kernel) and a quotient per axis for a non-empty window.
// Throughput: one beat at a time, set by the walk of the window memory (one entry read
// per pass) and the shared bit-serial divider used for every weight and every quotient.
// Reset: synchronous active-low rst_n clears control state, period returns to 5000 us;
// window memory needs no clearing since only counted entries are read; DIV_N = 40.
module triangle_kernel_resampler #(
  parameter int WINDOW_DEPTH = 32,
  parameter int MAX_BURST = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  tkr_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output tkr_pkg::out_item_t                  out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tkr_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [tkr_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [tkr_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);

  localparam int RB = tkr_pkg::RATE_BITS;
  localparam int PW_ = tkr_pkg::PERIOD_W;
  localparam int WW = tkr_pkg::WEIGHT_W;
  localparam int IW = $clog2(WINDOW_DEPTH);
  localparam int SW = IW + 1;
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int BW = $clog2(MAX_BURST + 1);
  localparam int WSW = WW + CW;
  localparam int AW = RB + WW + CW + 1;
  localparam int DIV_N = (AW > 31) ? AW : 31;
  localparam int PRW = WW + 1 + RB;
  localparam int MEM_W = tkr_pkg::TIME_W + 3 * RB;
  localparam int TW = tkr_pkg::GRID_W;
  localparam int CMPW = TW + 2;

  tkr_pkg::state_t state_r, state_nxt;

  logic [PW_-1:0]  period_r;
  logic [PW_-1:0]  p_eff;
  logic            started_r;
  logic [31:0]     origin_r;
  logic [31:0]     t_r;
  logic [31:0]     idx_r;
  logic [TW-1:0]   ts_r;
  logic [IW-1:0]   head_r;
  logic [CW-1:0]   count_r;
  logic            ovf_r;
  logic [BW-1:0]   n_r;
  logic [CW-1:0]   k_r;
  logic [WSW-1:0]  wsum_r;
  logic signed [AW-1:0]  acc_r [3];
  logic signed [PRW-1:0] prod_r [3];
  logic [WW-1:0]   w_r;
  logic [1:0]      axis_r;
  tkr_pkg::in_item_t  in_r;
  tkr_pkg::out_item_t res_r;
  tkr_pkg::out_item_t out_r;
  logic            out_valid_r;

  // window memory: time in the low word, then x, y, z rates
  logic [MEM_W-1:0] mem [WINDOW_DEPTH];
  logic [MEM_W-1:0] rd_q_r;
  logic             rd_en;
  logic             wr_en;
  logic [CW-1:0]    slot_off;
  logic [SW-1:0]    slot_sum;
  logic [SW-1:0]    slot_wrap;
  logic [IW-1:0]    slot_addr;

  logic             in_fire;
  logic             cfg_wr;
  logic [31:0]      rel_time;
  logic [31:0]      mem_time;
  logic [TW-1:0]    ti_ext;
  logic [TW-1:0]    gap;
  logic             in_win;
  logic [PW_-1:0]   pmd;
  logic             due;
  logic             expired;
  logic             full;
  logic [IW-1:0]    head_inc;
  logic             push_ok;

  logic             div_start;
  logic [DIV_N-1:0] div_dividend;
  logic [WSW-1:0]   div_divisor;
  logic             div_done;
  logic [DIV_N-1:0] div_quo;

  logic signed [AW-1:0] acc_sel;
  logic [AW-1:0]        acc_mag;
  logic signed [RB-1:0] sat_val;
  logic [DIV_N-1:0]     lim_pos;

  assign p_eff    = (period_r == '0) ? PW_'(1) : period_r;
  assign in_fire  = in_valid && in_ready;
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == tkr_pkg::REG_GRID_PERIOD);
  assign rel_time = in_data.sample_time - (started_r ? origin_r : in_data.sample_time);
  assign mem_time = rd_q_r[31:0];
  assign ti_ext   = TW'(mem_time);
  assign gap      = (ts_r > ti_ext) ? (ts_r - ti_ext) : (ti_ext - ts_r);
  assign in_win   = gap < TW'(p_eff);
  assign pmd      = p_eff - gap[PW_-1:0];
  assign due      = (n_r < BW'(MAX_BURST)) &&
                    (CMPW'(t_r) > CMPW'(ts_r) + CMPW'(p_eff) * CMPW'(tkr_pkg::LOOKAHEAD));
  assign expired  = ((TW + 1)'(mem_time) + (TW + 1)'(p_eff)) <= (TW + 1)'(ts_r);
  assign full     = count_r >= CW'(WINDOW_DEPTH);
  assign head_inc = (head_r == IW'(WINDOW_DEPTH - 1)) ? '0 : head_r + IW'(1);
  assign push_ok  = !out_valid_r || out_ready;

  // ring slot of head plus offset
  always_comb begin
    case (state_r)
      tkr_pkg::ST_READ:  slot_off = k_r;
      tkr_pkg::ST_WRITE: slot_off = count_r;
      default:           slot_off = '0;
    endcase
  end
  assign slot_sum  = SW'(head_r) + SW'(slot_off);
  assign slot_wrap = (slot_sum >= SW'(WINDOW_DEPTH)) ? slot_sum - SW'(WINDOW_DEPTH) : slot_sum;
  assign slot_addr = slot_wrap[IW-1:0];

  // memory access strobes
  assign rd_en = ((state_r == tkr_pkg::ST_READ) && (k_r != count_r)) ||
                 ((state_r == tkr_pkg::ST_PRUNE) && (count_r != '0)) ||
                 ((state_r == tkr_pkg::ST_INSERT) && full);
  assign wr_en = (state_r == tkr_pkg::ST_WRITE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[slot_addr] <= {in_r.rate_z, in_r.rate_y, in_r.rate_x, t_r};
    end
    if (rd_en) begin
      rd_q_r <= mem[slot_addr];
    end
  end

  // divider operand selection
  assign acc_sel = acc_r[axis_r];
  assign acc_mag = acc_sel[AW-1] ? AW'(-acc_sel) : AW'(acc_sel);
  assign div_start = (state_r == tkr_pkg::ST_READ_WAIT && in_win) ||
                     (state_r == tkr_pkg::ST_QDIV);
  always_comb begin
    if (state_r == tkr_pkg::ST_QDIV) begin
      div_dividend = DIV_N'(acc_mag);
      div_divisor  = wsum_r;
    end else begin
      div_dividend = DIV_N'(pmd) << tkr_pkg::FRAC_BITS;
      div_divisor  = WSW'(p_eff);
    end
  end

  tkr_divider #(.N(DIV_N), .M(WSW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // sign and saturate the quotient
  assign lim_pos = DIV_N'(1) << (RB - 1);
  always_comb begin
    if (acc_sel[AW-1]) begin
      sat_val = (div_quo > lim_pos) ? RB'(lim_pos) : RB'(-div_quo);
    end else begin
      sat_val = (div_quo >= lim_pos) ? RB'(lim_pos - DIV_N'(1)) : RB'(div_quo);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tkr_pkg::ST_IDLE:        if (in_fire) state_nxt = tkr_pkg::ST_GRID;
      tkr_pkg::ST_GRID:        state_nxt = tkr_pkg::ST_CHECK;
      tkr_pkg::ST_CHECK:       state_nxt = due ? tkr_pkg::ST_READ : tkr_pkg::ST_INSERT;
      tkr_pkg::ST_READ:        state_nxt = (k_r == count_r) ? tkr_pkg::ST_FINISH
                                                             : tkr_pkg::ST_READ_WAIT;
      tkr_pkg::ST_READ_WAIT:   state_nxt = in_win ? tkr_pkg::ST_WDIV : tkr_pkg::ST_READ;
      tkr_pkg::ST_WDIV:        if (div_done) state_nxt = tkr_pkg::ST_MAC;
      tkr_pkg::ST_MAC:         state_nxt = tkr_pkg::ST_ACC;
      tkr_pkg::ST_ACC:         state_nxt = tkr_pkg::ST_READ;
      tkr_pkg::ST_FINISH:      state_nxt = (wsum_r == '0) ? tkr_pkg::ST_ADVANCE
                                                          : tkr_pkg::ST_QDIV;
      tkr_pkg::ST_QDIV:        state_nxt = tkr_pkg::ST_QWAIT;
      tkr_pkg::ST_QWAIT:       if (div_done) begin
        state_nxt = (axis_r == 2'd2) ? tkr_pkg::ST_ADVANCE : tkr_pkg::ST_QDIV;
      end
      tkr_pkg::ST_ADVANCE:     state_nxt = tkr_pkg::ST_PRUNE;
      tkr_pkg::ST_PRUNE:       state_nxt = (count_r == '0) ? tkr_pkg::ST_LAST
                                                           : tkr_pkg::ST_PRUNE_WAIT;
      tkr_pkg::ST_PRUNE_WAIT:  state_nxt = expired ? tkr_pkg::ST_PRUNE : tkr_pkg::ST_LAST;
      tkr_pkg::ST_LAST:        state_nxt = tkr_pkg::ST_PUSH;
      tkr_pkg::ST_PUSH:        if (push_ok) state_nxt = tkr_pkg::ST_CHECK;
      tkr_pkg::ST_INSERT:      state_nxt = full ? tkr_pkg::ST_INSERT_WAIT
                                                : tkr_pkg::ST_WRITE;
      tkr_pkg::ST_INSERT_WAIT: state_nxt = tkr_pkg::ST_WRITE;
      tkr_pkg::ST_WRITE:       state_nxt = tkr_pkg::ST_IDLE;
      default:                 state_nxt = tkr_pkg::ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tkr_pkg::ST_IDLE;
      period_r    <= tkr_pkg::PERIOD_RESET;
      started_r   <= 1'b0;
      origin_r    <= '0;
      idx_r       <= '0;
      head_r      <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        period_r <= pwdata[PW_-1:0];
      end
      if (in_fire && !started_r) begin
        origin_r  <= in_data.sample_time;
        started_r <= 1'b1;
      end
      if (state_r == tkr_pkg::ST_ADVANCE) begin
        ovf_r <= 1'b0;
        idx_r <= idx_r + 32'd1;
      end
      if ((state_r == tkr_pkg::ST_PRUNE_WAIT && expired) ||
          state_r == tkr_pkg::ST_INSERT_WAIT) begin
        head_r  <= head_inc;
        count_r <= count_r - CW'(1);
      end
      if (state_r == tkr_pkg::ST_INSERT_WAIT && !expired) begin
        ovf_r <= 1'b1;
      end
      if (wr_en) begin
        count_r <= count_r + CW'(1);
      end
      // output register
      if (state_r == tkr_pkg::ST_PUSH && push_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      tkr_pkg::ST_IDLE: begin
        if (in_fire) begin
          t_r  <= rel_time;
          in_r <= in_data;
          n_r  <= '0;
        end
      end
      tkr_pkg::ST_GRID: begin
        ts_r <= TW'(idx_r) * TW'(p_eff);
      end
      tkr_pkg::ST_CHECK: begin
        k_r    <= '0;
        wsum_r <= '0;
        axis_r <= 2'd0;
        for (int a = 0; a < 3; a++) begin
          acc_r[a] <= '0;
        end
      end
      tkr_pkg::ST_READ_WAIT: begin
        if (!in_win) k_r <= k_r + CW'(1);
      end
      tkr_pkg::ST_WDIV: begin
        w_r <= div_quo[WW-1:0];
      end
      tkr_pkg::ST_MAC: begin
        wsum_r <= wsum_r + WSW'(w_r);
        for (int a = 0; a < 3; a++) begin
          prod_r[a] <= $signed({1'b0, w_r}) * $signed(rd_q_r[32 + a * RB +: RB]);
        end
      end
      tkr_pkg::ST_ACC: begin
        k_r <= k_r + CW'(1);
        for (int a = 0; a < 3; a++) begin
          acc_r[a] <= acc_r[a] + AW'(prod_r[a]);
        end
      end
      tkr_pkg::ST_FINISH: begin
        res_r.window_empty <= (wsum_r == '0);
        res_r.out_x <= '0;
        res_r.out_y <= '0;
        res_r.out_z <= '0;
      end
      tkr_pkg::ST_QWAIT: begin
        if (div_done) begin
          axis_r <= axis_r + 2'd1;
          case (axis_r)
            2'd0:    res_r.out_x <= sat_val;
            2'd1:    res_r.out_y <= sat_val;
            default: res_r.out_z <= sat_val;
          endcase
        end
      end
      tkr_pkg::ST_ADVANCE: begin
        res_r.grid_time       <= ts_r[31:0];
        res_r.window_overflow <= ovf_r;
        n_r  <= n_r + BW'(1);
        ts_r <= (idx_r == '1) ? '0 : ts_r + TW'(p_eff);
      end
      tkr_pkg::ST_LAST: begin
        res_r.last_of_burst <= !due;
      end
      tkr_pkg::ST_PUSH: begin
        if (push_ok) out_r <= res_r;
      end
      default: begin
      end
    endcase
  end

  assign in_ready  = (state_r == tkr_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == tkr_pkg::REG_GRID_PERIOD) ?
                     tkr_pkg::APB_DATA_W'(period_r) : '0;

endmodule

FILE: hw/rtl/tkr_checker.sv
// port-level checks of the resampler, bound to the top level
module tkr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input tkr_pkg::out_item_t out_data,
  input logic               pready
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // an empty window reports zero rates
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.window_empty |->
      out_data.out_x == '0 && out_data.out_y == '0 && out_data.out_z == '0)
    else $error("empty window with nonzero rates");

  // reset drops any pending result
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // the config port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("pready low");

endmodule

bind triangle_kernel_resampler tkr_checker u_tkr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .pready    (pready)
);
